### hdl/sorted_priority_queue_core_macros.svh
// Assertion macros shared by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge and quiet while in reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// Next-cycle implication, sampled on the rising edge and quiet while in reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

### hdl/spq_pkg.sv
// Package with the constants, codes and types of the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int Capacity = 16;
    localparam int CountW   = $clog2(Capacity + 1);
    localparam int ValueW   = 32;
    localparam int OutCntW  = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                     insert_en;
        logic                     remove_en;
        logic signed [ValueW-1:0] value;
    } cell_ctrl_t;

    // Compare results that each cell reports.
    typedef struct packed {
        logic gt;
        logic match;
    } cell_flags_t;

endpackage
`default_nettype wire

### hdl/spq_cell.sv
// One cell of the sorted chain: holds one entry and moves it left or right.
`default_nettype none
module spq_cell (
    input  wire logic                             clk,
    input  wire spq_pkg::cell_ctrl_t              ctrl,
    input  wire logic                             occupied,
    input  wire logic signed [spq_pkg::ValueW-1:0] left_value,
    input  wire logic                             left_gt,
    input  wire logic signed [spq_pkg::ValueW-1:0] right_value,
    output logic signed [spq_pkg::ValueW-1:0]     entry_value,
    output logic signed [spq_pkg::ValueW-1:0]     entry_next,
    output spq_pkg::cell_flags_t                  flags
);

    logic signed [spq_pkg::ValueW-1:0] entry_reg;

    assign entry_value = entry_reg;
    assign flags.gt    = occupied && (entry_reg > ctrl.value);
    assign flags.match = occupied && (entry_reg == ctrl.value);

    // Cells holding larger values stay; the first other cell takes the new
    // value on insert, and the rest shift towards the tail or the head.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en && !flags.gt)
        begin
            entry_next = left_gt ? ctrl.value : left_value;
        end
        else if (ctrl.remove_en && !flags.gt)
        begin
            entry_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

### hdl/sorted_priority_queue_core.sv
// A result appears in the output register in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; every cell compares against the broadcast value and
// the whole chain shifts in that same cycle. While a result waits unclaimed the input stalls;
// the next transaction goes in at the edge where the waiting result is taken. Reset clears the
// entry count and the output valid; cell contents are not reset, since only entries below the
// count are ever read.
`default_nettype none
module sorted_priority_queue_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       action,
    input  wire logic signed [spq_pkg::ValueW-1:0] value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  op_ok,
    output logic signed [spq_pkg::ValueW-1:0]     head_value,
    output logic                                  queue_empty,
    output logic [spq_pkg::OutCntW-1:0]           entry_count,
    output logic                                  queue_full
);

    // Number of valid entries; cells at or beyond it hold stale data.
    logic [spq_pkg::CountW-1:0] count_reg;
    logic [spq_pkg::CountW-1:0] count_next;

    logic                              out_valid_reg;
    logic                              op_ok_reg;
    logic signed [spq_pkg::ValueW-1:0] head_reg;
    logic                              empty_reg;
    logic [spq_pkg::OutCntW-1:0]       count_out_reg;
    logic                              full_reg;

    logic                 accept;
    logic                 found;
    logic                 is_full;
    logic                 ok_next;
    spq_pkg::action_t     act;
    spq_pkg::cell_ctrl_t  ctrl;

    logic        [spq_pkg::Capacity-1:0]  occ;
    logic        [spq_pkg::Capacity-1:0]  gt_vec;
    logic        [spq_pkg::Capacity-1:0]  match_vec;
    spq_pkg::cell_flags_t                 flags   [spq_pkg::Capacity];
    logic signed [spq_pkg::ValueW-1:0]    cur_val [spq_pkg::Capacity];
    logic signed [spq_pkg::ValueW-1:0]    nxt_val [spq_pkg::Capacity];

    // The output register frees up whenever the waiting result is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign act      = spq_pkg::action_t'(action);
    assign is_full  = (count_reg == spq_pkg::CountW'(spq_pkg::Capacity));
    assign found    = |match_vec;

    // One broadcast word drives the whole chain. A remove only shifts when the value exists.
    always_comb
    begin
        ctrl.value     = value;
        ctrl.insert_en = accept && (act == spq_pkg::ACT_INSERT) && !is_full;
        ctrl.remove_en = accept && (act == spq_pkg::ACT_REMOVE) && found;
    end

    // The chain itself. Entries are kept in descending order, so the cells whose value
    // exceeds the key form a prefix; the boundary of that prefix is where an insert lands
    // and, equally, where the first equal entry sits for a remove.
    for (genvar i = 0; i < spq_pkg::Capacity; i++)
    begin : g_cell
        logic signed [spq_pkg::ValueW-1:0] left_v;
        logic                              left_g;
        logic signed [spq_pkg::ValueW-1:0] right_v;

        assign occ[i]       = (count_reg > spq_pkg::CountW'(i));
        assign gt_vec[i]    = flags[i].gt;
        assign match_vec[i] = flags[i].match;

        if (i == 0)
        begin : g_head
            assign left_v = value;
            assign left_g = 1'b1;
        end
        else
        begin : g_body
            assign left_v = cur_val[i-1];
            assign left_g = gt_vec[i-1];
        end

        if (i == spq_pkg::Capacity - 1)
        begin : g_tail
            assign right_v = cur_val[i];
        end
        else
        begin : g_inner
            assign right_v = cur_val[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_value  (left_v),
            .left_gt     (left_g),
            .right_value (right_v),
            .entry_value (cur_val[i]),
            .entry_next  (nxt_val[i]),
            .flags       (flags[i])
        );
    end

    // Count update and success flag for the transaction being accepted.
    always_comb
    begin
        count_next = count_reg;
        ok_next    = 1'b0;
        case (act)
            spq_pkg::ACT_INSERT:
            begin
                ok_next = !is_full;
                if (ctrl.insert_en)
                begin
                    count_next = count_reg + spq_pkg::CountW'(1);
                end
            end
            spq_pkg::ACT_REMOVE:
            begin
                ok_next = found;
                if (ctrl.remove_en)
                begin
                    count_next = count_reg - spq_pkg::CountW'(1);
                end
            end
            spq_pkg::ACT_FIND:
            begin
                ok_next = found;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload describes the store after the operation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_ok_reg     <= ok_next;
            head_reg      <= (count_next != '0) ? nxt_val[0] : '0;
            empty_reg     <= (count_next == '0);
            count_out_reg <= spq_pkg::OutCntW'(count_next);
            full_reg      <= (count_next == spq_pkg::CountW'(spq_pkg::Capacity));
        end
    end

    assign out_valid   = out_valid_reg;
    assign op_ok       = op_ok_reg;
    assign head_value  = head_reg;
    assign queue_empty = empty_reg;
    assign entry_count = count_out_reg;
    assign queue_full  = full_reg;

endmodule
`default_nettype wire

### hdl/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`default_nettype none
`include "sorted_priority_queue_core_macros.svh"
module spq_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic                             op_ok,
    input wire logic signed [spq_pkg::ValueW-1:0] head_value,
    input wire logic                             queue_empty,
    input wire logic [spq_pkg::OutCntW-1:0]      entry_count,
    input wire logic                             queue_full
);

    `SPQ_ASSERT_NOW(a_not_full_and_empty, out_valid, !(queue_full && queue_empty))
    `SPQ_ASSERT_NOW(a_empty_status, out_valid && queue_empty, (entry_count == '0) && (head_value == '0))
    `SPQ_ASSERT_NOW(a_count_means_nonempty, out_valid && (entry_count != '0), !queue_empty)
    `SPQ_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(head_value) && $stable(op_ok))

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .op_ok       (op_ok),
    .head_value  (head_value),
    .queue_empty (queue_empty),
    .entry_count (entry_count),
    .queue_full  (queue_full)
);
`default_nettype wire
